@@ sv/cst_pkg.sv @@
// Shared types and constants for the color spot centroid tracker.
`timescale 1ns / 1ps

package cst_pkg;

  // Frame geometry and history ring
  localparam int MaxRows   = 1024;
  localparam int MaxCols   = 1024;
  localparam int HistDepth = 4;
  localparam int FracBits  = 4;

  // Field widths
  localparam int PixW   = 8;
  localparam int ThrW   = 9;
  localparam int RowW   = $clog2(MaxRows);
  localparam int ColW   = $clog2(MaxCols);
  localparam int CountW = 21;
  localparam int SumW   = 30;
  localparam int CoordW = 14;

  // History ring indexing and averaging
  localparam int SlotW  = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int ValidW = $clog2(HistDepth + 1);
  localparam int AvgW   = CoordW + ValidW;

  // Divider widths: dividend is a sum scaled by the fraction bits
  localparam int DivW    = SumW + FracBits;
  localparam int HiW     = DivW - CoordW;
  localparam int CmpW    = (HiW > CountW) ? HiW : CountW;
  localparam int DivCntW = $clog2(CoordW + 1);

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic signed [ThrW-1:0] ThreshReset = 9'sd80;
  localparam logic [CountW-1:0]      CountMax    = {CountW{1'b1}};

  // Per-frame totals handed from front to back
  typedef struct packed {
    logic [SumW-1:0]   row_sum;
    logic [SumW-1:0]   col_sum;
    logic [CountW-1:0] lit_count;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ROW  = 7'b0000010,
    ST_COL  = 7'b0000100,
    ST_SUM  = 7'b0001000,
    ST_AST  = 7'b0010000,
    ST_AROW = 7'b0100000,
    ST_ACOL = 7'b1000000
  } back_state_e;

endpackage

@@ sv/cst_front.sv @@
// Pixel front end: threshold test, raster counters and per-frame accumulators.
`timescale 1ns / 1ps

module cst_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cst_pkg::ThrW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cst_pkg::PixW-1:0]   a_value_i,
  input  logic [cst_pkg::PixW-1:0]   b_value_i,
  input  logic                       line_end_i,
  input  logic                       frame_end_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output cst_pkg::job_t              q_data_o
);

  logic signed [cst_pkg::ThrW-1:0]   thr_q;
  logic [cst_pkg::RowW-1:0]          row_q, row_d;
  logic [cst_pkg::ColW-1:0]          col_q, col_d;
  logic [cst_pkg::CountW-1:0]        cnt_q, cnt_d, cnt_acc;
  logic [cst_pkg::SumW-1:0]          rsum_q, rsum_d, rsum_acc;
  logic [cst_pkg::SumW-1:0]          csum_q, csum_d, csum_acc;
  logic [cst_pkg::SumW:0]            rs_add, cs_add;
  logic signed [cst_pkg::PixW+1:0]   diff;
  logic signed [cst_pkg::PixW+1:0]   thr_ext;
  logic                              lit, take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  // Threshold test on b minus a
  assign diff    = $signed({2'b00, b_value_i}) - $signed({2'b00, a_value_i});
  assign thr_ext = (cst_pkg::PixW + 2)'(thr_q);
  assign lit     = (diff >= thr_ext) && (cnt_q != cst_pkg::CountMax);

  // Saturating coordinate sums
  assign rs_add = {1'b0, rsum_q} + (cst_pkg::SumW + 1)'(row_q);
  assign cs_add = {1'b0, csum_q} + (cst_pkg::SumW + 1)'(col_q);

  always_comb begin
    cnt_acc  = cnt_q;
    rsum_acc = rsum_q;
    csum_acc = csum_q;
    if (lit) begin
      cnt_acc  = cnt_q + 1'b1;
      rsum_acc = rs_add[cst_pkg::SumW] ? {cst_pkg::SumW{1'b1}} : rs_add[cst_pkg::SumW-1:0];
      csum_acc = cs_add[cst_pkg::SumW] ? {cst_pkg::SumW{1'b1}} : cs_add[cst_pkg::SumW-1:0];
    end
  end

  // Raster position and frame wrap
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    cnt_d  = cnt_acc;
    rsum_d = rsum_acc;
    csum_d = csum_acc;
    if (line_end_i) begin
      col_d = '0;
      if (row_q != cst_pkg::RowW'(cst_pkg::MaxRows - 1)) row_d = row_q + 1'b1;
    end else if (col_q != cst_pkg::ColW'(cst_pkg::MaxCols - 1)) begin
      col_d = col_q + 1'b1;
    end
    if (frame_end_i) begin
      row_d  = '0;
      col_d  = '0;
      cnt_d  = '0;
      rsum_d = '0;
      csum_d = '0;
    end
  end

  assign q_push_o           = take && frame_end_i;
  assign q_data_o.row_sum   = rsum_acc;
  assign q_data_o.col_sum   = csum_acc;
  assign q_data_o.lit_count = cnt_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= cst_pkg::ThreshReset;
      row_q  <= '0;
      col_q  <= '0;
      cnt_q  <= '0;
      rsum_q <= '0;
      csum_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= $signed(cfg_wdata_i);
      if (take) begin
        row_q  <= row_d;
        col_q  <= col_d;
        cnt_q  <= cnt_d;
        rsum_q <= rsum_d;
        csum_q <= csum_d;
      end
    end
  end

endmodule

@@ sv/cst_queue.sv @@
// Short job queue between the pixel front end and the frame-end back end.
`timescale 1ns / 1ps

module cst_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cst_pkg::job_t push_data_i,
  input  logic          pop_i,
  output cst_pkg::job_t head_o,
  output logic          full_o,
  output logic          empty_o
);

  cst_pkg::job_t            mem_q [cst_pkg::QDepth];
  logic [cst_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [cst_pkg::QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (cst_pkg::QPtrW + 1)'(cst_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == cst_pkg::QPtrW'(cst_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == cst_pkg::QPtrW'(cst_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ sv/cst_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating quotient.
`timescale 1ns / 1ps

module cst_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cst_pkg::div_req_t req_i,
  output cst_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, done_q;
  logic [cst_pkg::CountW-1:0]    rem_q, dvs_q;
  logic [cst_pkg::CoordW-1:0]    low_q, quo_q;
  logic [cst_pkg::DivCntW-1:0]   cnt_q;
  logic [cst_pkg::HiW-1:0]       hi;
  logic                          ovf;
  logic [cst_pkg::CountW:0]      trial, trial_sub;
  logic                          fits;

  // Quotient overflows when the upper dividend part already reaches the divisor
  assign hi  = req_i.dividend[cst_pkg::DivW-1:cst_pkg::CoordW];
  assign ovf = cst_pkg::CmpW'(hi) >= cst_pkg::CmpW'(req_i.divisor);

  // One restoring step
  assign trial     = {rem_q, low_q[cst_pkg::CoordW-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        if (req_i.divisor == '0 || ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= cst_pkg::DivCntW'(cst_pkg::CoordW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == cst_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      dvs_q <= req_i.divisor;
      rem_q <= cst_pkg::CountW'(hi);
      low_q <= req_i.dividend[cst_pkg::CoordW-1:0];
      if (req_i.divisor == '0) quo_q <= '0;
      else if (ovf)            quo_q <= '1;
      else                     quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[cst_pkg::CountW-1:0] : trial[cst_pkg::CountW-1:0];
      low_q <= low_q << 1;
      quo_q <= {quo_q[cst_pkg::CoordW-2:0], fits};
    end
  end

endmodule

@@ sv/cst_back.sv @@
// Frame-end back end: centroid division, history ring, averaging, output register.
`timescale 1ns / 1ps

module cst_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cst_pkg::job_t              head_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cst_pkg::CoordW-1:0] centroid_row_o,
  output logic [cst_pkg::CoordW-1:0] centroid_col_o,
  output logic                       spot_found_o,
  output logic [cst_pkg::CountW-1:0] frame_lit_pixels_o
);

  cst_pkg::back_state_e         state_q, state_d;
  cst_pkg::job_t                job_q;
  cst_pkg::div_req_t            dreq;
  cst_pkg::div_rsp_t            drsp;
  logic [cst_pkg::CoordW-1:0]   cent_row_q;
  logic [cst_pkg::CoordW-1:0]   hist_row_q [cst_pkg::HistDepth];
  logic [cst_pkg::CoordW-1:0]   hist_col_q [cst_pkg::HistDepth];
  logic [cst_pkg::SlotW-1:0]    slot_q;
  logic [cst_pkg::AvgW-1:0]     sr_q, sc_q, sr_d, sc_d;
  logic [cst_pkg::ValidW-1:0]   nvalid_q, nvalid_d;
  logic [cst_pkg::CoordW-1:0]   avg_row_q;
  logic                         avg_done_q;
  logic                         out_free, hist_we, load_out;
  logic [cst_pkg::CoordW-1:0]   out_row_d, out_col_d;
  logic                         out_found_d;

  cst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign out_free = !out_valid_o || out_ready_i;

  // Sum of history entries with both coordinates above zero
  always_comb begin
    sr_d     = '0;
    sc_d     = '0;
    nvalid_d = '0;
    for (int i = 0; i < cst_pkg::HistDepth; i++) begin
      if (hist_row_q[i] != '0 && hist_col_q[i] != '0) begin
        sr_d     = sr_d + cst_pkg::AvgW'(hist_row_q[i]);
        sc_d     = sc_d + cst_pkg::AvgW'(hist_col_q[i]);
        nvalid_d = nvalid_d + 1'b1;
      end
    end
  end

  // Sequencer: row centroid, column centroid, ring update, averages
  always_comb begin
    state_d       = state_q;
    pop_o         = 1'b0;
    hist_we       = 1'b0;
    load_out      = 1'b0;
    out_row_d     = drsp.quotient;
    out_col_d     = drsp.quotient;
    out_found_d   = 1'b1;
    dreq.start    = 1'b0;
    dreq.dividend = cst_pkg::DivW'(head_i.row_sum) << cst_pkg::FracBits;
    dreq.divisor  = head_i.lit_count;
    case (state_q)
      cst_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          dreq.start = 1'b1;
          state_d    = cst_pkg::ST_ROW;
        end
      end
      cst_pkg::ST_ROW: begin
        dreq.dividend = cst_pkg::DivW'(job_q.col_sum) << cst_pkg::FracBits;
        dreq.divisor  = job_q.lit_count;
        if (drsp.done) begin
          dreq.start = 1'b1;
          state_d    = cst_pkg::ST_COL;
        end
      end
      cst_pkg::ST_COL: begin
        if (drsp.done) begin
          hist_we = 1'b1;
          state_d = cst_pkg::ST_SUM;
        end
      end
      cst_pkg::ST_SUM: begin
        state_d = cst_pkg::ST_AST;
      end
      cst_pkg::ST_AST: begin
        dreq.dividend = cst_pkg::DivW'(sr_q);
        dreq.divisor  = cst_pkg::CountW'(nvalid_q);
        if (nvalid_q == '0) begin
          out_row_d   = '0;
          out_col_d   = '0;
          out_found_d = 1'b0;
          if (out_free) begin
            load_out = 1'b1;
            state_d  = cst_pkg::ST_IDLE;
          end
        end else begin
          dreq.start = 1'b1;
          state_d    = cst_pkg::ST_AROW;
        end
      end
      cst_pkg::ST_AROW: begin
        dreq.dividend = cst_pkg::DivW'(sc_q);
        dreq.divisor  = cst_pkg::CountW'(nvalid_q);
        if (drsp.done) begin
          dreq.start = 1'b1;
          state_d    = cst_pkg::ST_ACOL;
        end
      end
      cst_pkg::ST_ACOL: begin
        // quotient holds after done until the next job starts
        out_row_d = avg_row_q;
        if ((drsp.done || avg_done_q) && out_free) begin
          load_out = 1'b1;
          state_d  = cst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state, ring and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cst_pkg::ST_IDLE;
      slot_q      <= '0;
      out_valid_o <= 1'b0;
      avg_done_q  <= 1'b0;
      for (int i = 0; i < cst_pkg::HistDepth; i++) begin
        hist_row_q[i] <= '0;
        hist_col_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (hist_we) begin
        hist_row_q[slot_q] <= cent_row_q;
        hist_col_q[slot_q] <= drsp.quotient;
        slot_q <= (slot_q == cst_pkg::SlotW'(cst_pkg::HistDepth - 1)) ? '0 : slot_q + 1'b1;
      end
      // Column average finished while the output register was still busy
      if (load_out) avg_done_q <= 1'b0;
      else if (state_q == cst_pkg::ST_ACOL && drsp.done) avg_done_q <= 1'b1;
      if (load_out)         out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= head_i;
    if (state_q == cst_pkg::ST_ROW && drsp.done) cent_row_q <= drsp.quotient;
    if (state_q == cst_pkg::ST_SUM) begin
      sr_q     <= sr_d;
      sc_q     <= sc_d;
      nvalid_q <= nvalid_d;
    end
    if (state_q == cst_pkg::ST_AROW && drsp.done) avg_row_q <= drsp.quotient;
    if (load_out) begin
      centroid_row_o     <= out_row_d;
      centroid_col_o     <= out_col_d;
      spot_found_o       <= out_found_d;
      frame_lit_pixels_o <= job_q.lit_count;
    end
  end

endmodule

@@ sv/color_spot_centroid_tracker_top.sv @@
// Top level of the color spot centroid tracker.
//
// Input channel: one Lab pixel (a, b bytes) per item with line_end and
// frame_end marks, raster order. Pixels are taken at one per cycle; the input
// stalls only while both frame-end queue slots are full.
// Output channel: one item per frame end with the averaged centroid of the
// history ring (4 fraction bits), a found flag and the frame's lit count.
// The back end runs four divisions on one shared restoring divider; a
// division ends at once when its quotient is known (zero count or saturation).
// An empty frame with no valid history entry runs only the two centroid
// divisions. The back end serves one frame end at a time and takes no new one
// before it is through with the last; up to two frames wait in the queue.
// cfg_we_i writes the signed lit threshold (b minus a); write it only while
// the block is idle. Reset restores the threshold to 80, clears the raster
// counters, sums, queue and history ring. A stalled output holds its item
// in the output register; the back end then waits, the queue fills and the
// front end stops taking pixels.
`timescale 1ns / 1ps

module color_spot_centroid_tracker_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cst_pkg::ThrW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cst_pkg::PixW-1:0]   a_value_i,
  input  logic [cst_pkg::PixW-1:0]   b_value_i,
  input  logic                       line_end_i,
  input  logic                       frame_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cst_pkg::CoordW-1:0] centroid_row_o,
  output logic [cst_pkg::CoordW-1:0] centroid_col_o,
  output logic                       spot_found_o,
  output logic [cst_pkg::CountW-1:0] frame_lit_pixels_o
);

  logic          q_push, q_pop, q_full, q_empty;
  cst_pkg::job_t q_in, q_head;

  cst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_value_i   (a_value_i),
    .b_value_i   (b_value_i),
    .line_end_i  (line_end_i),
    .frame_end_i (frame_end_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  cst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  cst_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (q_head),
    .empty_i            (q_empty),
    .pop_o              (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .centroid_row_o     (centroid_row_o),
    .centroid_col_o     (centroid_col_o),
    .spot_found_o       (spot_found_o),
    .frame_lit_pixels_o (frame_lit_pixels_o)
  );

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("frame job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("frame job popped from an empty queue");

  // Every accepted frame end hands a job to the back end
  a_frame_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && frame_end_i) |-> q_push)
    else $error("frame end accepted without a queued job");

  // Not-found results carry zero coordinates
  a_zero_when_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !spot_found_o) |-> (centroid_row_o == '0 && centroid_col_o == '0))
    else $error("coordinates nonzero without a found spot");

endmodule
